[rtl/core/ssrg_pkg.sv]
// ----------------------------------------------------------------------------
// ssrg_pkg
// Shared types and constants of the stepper step-rate generator: function
// codes, register indexes, field widths and controller/datapath links.
// ----------------------------------------------------------------------------
package ssrg_pkg;

    localparam int PERIOD_WIDTH_DEF = 32;

    // configuration register widths
    localparam int SPR_W  = 16;
    localparam int GEAR_W = 16;
    localparam int TPS_W  = 20;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 20;

    localparam logic [SPR_W-1:0]  SPR_RST  = 16'd200;
    localparam logic [GEAR_W-1:0] GEAR_RST = 16'd256;
    localparam logic [TPS_W-1:0]  TPS_RST  = 20'd1000000;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_STEPS_PER_REV    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GEAR_RATIO       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TICKS_PER_SECOND = 2'd2;

    // function codes carried in tuser
    localparam int FUNC_W = 2;
    localparam logic [FUNC_W-1:0] FN_TICK     = 2'd0;
    localparam logic [FUNC_W-1:0] FN_VELOCITY = 2'd1;
    localparam logic [FUNC_W-1:0] FN_ENABLE   = 2'd2;

    // velocity in signed Q1.14
    localparam int VEL_W = 16;
    localparam int MAG_W = 15;
    localparam logic signed [VEL_W-1:0] VEL_ONE     = 16'sd16384;
    localparam logic signed [VEL_W-1:0] VEL_NEG_ONE = -16'sd16384;

    // divider operand widths: numerator tps*gear*64, denominator |v|*spr
    localparam int NUM_SHIFT = 6;
    localparam int NUM_W = TPS_W + GEAR_W + NUM_SHIFT;
    localparam int DEN_W = MAG_W + SPR_W;
    localparam int CNT_W = $clog2(NUM_W);

    // stream widths, rounded up to whole bytes
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_ssrg_state;

    typedef struct packed {
        logic take;      // input beat accepted this cycle
        logic div_load;  // register products, seed the divider
        logic div_step;  // one quotient bit
        logic finish;    // store period, emit velocity result
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;  // output register full and not drained this cycle
        logic div_last;  // final quotient bit in progress
    } t_dp_sts;

endpackage

[rtl/core/stepper_step_rate_generator.sv]
// ----------------------------------------------------------------------------
// stepper_step_rate_generator
// Step-rate generator for a stepper motor: turns velocity commands into a
// step period by one division, then steps on the tick stream.
//
//   channel  direction  handshake                      payload
//   s_axis   in         s_axis_tvalid / s_axis_tready  tuser func, tdata velocity, enable
//   m_axis   out        m_axis_tvalid / m_axis_tready  tdata step, dir, enable, velocity
//   cfg      in         i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// tick, enable and unused codes need no sequencing; the result is loaded at accept.
// a velocity command passes through a product stage, the restoring divider
// (one quotient bit a cycle) and a finish state that loads the result.
// i_rst_n is synchronous, active low; no clearing pass is needed after reset.
// a result held in the output register stalls input only when it is not taken.
// ----------------------------------------------------------------------------
module stepper_step_rate_generator #(
    parameter int PERIOD_WIDTH = ssrg_pkg::PERIOD_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [15:0] velocity, [16] enable_value
    input  logic [ssrg_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // [1:0] func
    input  logic [ssrg_pkg::FUNC_W-1:0]         s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] step, [1] direction, [2] enable, [18:3] velocity_now
    output logic [ssrg_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ssrg_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [ssrg_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    ssrg_pkg::t_dp_cmd cmd;
    ssrg_pkg::t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    ssrg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_func     (s_axis_tuser),
        .i_sts      (sts),
        .o_s_tready (s_axis_tready),
        .o_cmd      (cmd)
    );

    ssrg_dp #(
        .PERIOD_WIDTH (PERIOD_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_func         (s_axis_tuser),
        .i_velocity     (s_axis_tdata[ssrg_pkg::VEL_W-1:0]),
        .i_enable_value (s_axis_tdata[ssrg_pkg::VEL_W]),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_m_tready     (m_axis_tready),
        .o_m_tvalid     (m_axis_tvalid),
        .o_m_tdata      (m_axis_tdata)
    );

endmodule

[rtl/core/ssrg_ctrl.sv]
// ----------------------------------------------------------------------------
// ssrg_ctrl
// Sequencer of the step-rate generator: input handshake and the order of
// multiply, divide and finish for velocity commands.
// ----------------------------------------------------------------------------
module ssrg_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic [ssrg_pkg::FUNC_W-1:0]   i_func,
    input  ssrg_pkg::t_dp_sts             i_sts,
    output logic                          o_s_tready,
    output ssrg_pkg::t_dp_cmd             o_cmd
);

    ssrg_pkg::t_ssrg_state r_state;
    ssrg_pkg::t_ssrg_state n_state;
    logic                  take;

    assign o_s_tready = (r_state == ssrg_pkg::ST_IDLE) && !i_sts.out_busy;
    assign take       = o_s_tready && i_s_tvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssrg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ssrg_pkg::ST_IDLE: begin
                if (take && i_func == ssrg_pkg::FN_VELOCITY) begin
                    n_state = ssrg_pkg::ST_MUL;
                end
            end
            ssrg_pkg::ST_MUL: begin
                n_state = ssrg_pkg::ST_DIV;
            end
            ssrg_pkg::ST_DIV: begin
                if (i_sts.div_last) begin
                    n_state = ssrg_pkg::ST_DONE;
                end
            end
            ssrg_pkg::ST_DONE: begin
                n_state = ssrg_pkg::ST_IDLE;
            end
            default: begin
                n_state = ssrg_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ssrg_pkg::ST_IDLE: begin
                o_cmd.take = take;
            end
            ssrg_pkg::ST_MUL: begin
                o_cmd.div_load = 1'b1;
            end
            ssrg_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            ssrg_pkg::ST_DONE: begin
                o_cmd.finish = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // the divider runs uninterrupted until its last bit
    a_div_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ssrg_pkg::ST_DIV && !i_sts.div_last) |=> (r_state == ssrg_pkg::ST_DIV))
        else $error("divider left before last bit");

    // a velocity command always goes to the multiply step next
    a_vel_to_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_func == ssrg_pkg::FN_VELOCITY) |=> (r_state == ssrg_pkg::ST_MUL))
        else $error("velocity command not sequenced");

endmodule

[rtl/core/ssrg_dp.sv]
// ----------------------------------------------------------------------------
// ssrg_dp
// Datapath of the step-rate generator: configuration registers, motion
// state, tick counter, product stage, restoring divider, output register.
// ----------------------------------------------------------------------------
module ssrg_dp #(
    parameter int PERIOD_WIDTH = ssrg_pkg::PERIOD_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ssrg_pkg::t_dp_cmd                 i_cmd,
    output ssrg_pkg::t_dp_sts                 o_sts,
    input  logic [ssrg_pkg::FUNC_W-1:0]       i_func,
    input  logic signed [ssrg_pkg::VEL_W-1:0] i_velocity,
    input  logic                              i_enable_value,
    input  logic                              i_cfg_valid,
    input  logic [ssrg_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [ssrg_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_m_tready,
    output logic                              o_m_tvalid,
    output logic [ssrg_pkg::M_TDATA_W-1:0]    o_m_tdata
);

    localparam int NUM_W = ssrg_pkg::NUM_W;
    localparam int DEN_W = ssrg_pkg::DEN_W;
    localparam int CNT_W = ssrg_pkg::CNT_W;
    localparam int VEL_W = ssrg_pkg::VEL_W;
    localparam int OUT_USED = 3 + VEL_W;

    // configuration
    logic [ssrg_pkg::SPR_W-1:0]  r_spr;
    logic [ssrg_pkg::GEAR_W-1:0] r_gear;
    logic [ssrg_pkg::TPS_W-1:0]  r_tps;

    // motion state
    logic signed [VEL_W-1:0]  r_velocity;
    logic                     r_dir;
    logic                     r_en;
    logic [PERIOD_WIDTH-1:0]  r_period;
    logic [PERIOD_WIDTH-1:0]  r_elapsed;

    // divider
    logic [NUM_W-1:0]         r_quo;
    logic [DEN_W-1:0]         r_rem;
    logic [DEN_W-1:0]         r_den;
    logic [CNT_W-1:0]         r_cnt;

    // output register
    logic                     r_out_valid;
    logic [OUT_USED-1:0]      r_out_data;

    logic signed [VEL_W-1:0]  vel_clamp;
    logic [VEL_W-1:0]         vel_abs;
    logic [ssrg_pkg::MAG_W-1:0] mag;
    logic [ssrg_pkg::TPS_W+ssrg_pkg::GEAR_W-1:0] num_prod;
    logic [DEN_W-1:0]         den_prod;
    logic [DEN_W:0]           rem_shift;
    logic [DEN_W:0]           rem_diff;
    logic                     quo_bit;
    logic [PERIOD_WIDTH-1:0]  elapsed_inc;
    logic                     tick_step;
    logic                     quo_sat;
    logic [PERIOD_WIDTH-1:0]  period_new;
    logic                     is_tick;
    logic                     is_vel;
    logic                     is_en;
    logic                     out_load;

    assign is_tick = i_cmd.take && (i_func == ssrg_pkg::FN_TICK);
    assign is_vel  = i_cmd.take && (i_func == ssrg_pkg::FN_VELOCITY);
    assign is_en   = i_cmd.take && (i_func == ssrg_pkg::FN_ENABLE);

    always_comb begin
        if (i_velocity > ssrg_pkg::VEL_ONE) begin
            vel_clamp = ssrg_pkg::VEL_ONE;
        end else if (i_velocity < ssrg_pkg::VEL_NEG_ONE) begin
            vel_clamp = ssrg_pkg::VEL_NEG_ONE;
        end else begin
            vel_clamp = i_velocity;
        end
    end

    // clamped value is within +-16384, so the magnitude fits 15 bits
    assign vel_abs  = r_velocity[VEL_W-1] ? VEL_W'(-r_velocity) : VEL_W'(r_velocity);
    assign mag      = vel_abs[ssrg_pkg::MAG_W-1:0];
    assign num_prod = r_tps * r_gear;
    assign den_prod = mag * r_spr;

    assign rem_shift = {r_rem, r_quo[NUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, r_den};
    assign quo_bit   = !rem_diff[DEN_W];

    generate
        if (NUM_W > PERIOD_WIDTH) begin : g_sat
            assign quo_sat = |r_quo[NUM_W-1:PERIOD_WIDTH];
        end else begin : g_nosat
            assign quo_sat = 1'b0;
        end
    endgenerate

    assign period_new = (r_den == '0 || quo_sat) ? '1 : PERIOD_WIDTH'(r_quo);

    assign elapsed_inc = (r_elapsed == '1) ? r_elapsed : r_elapsed + 1'b1;
    assign tick_step   = elapsed_inc > r_period;

    assign out_load = i_cmd.take ? !is_vel : i_cmd.finish;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spr       <= ssrg_pkg::SPR_RST;
            r_gear      <= ssrg_pkg::GEAR_RST;
            r_tps       <= ssrg_pkg::TPS_RST;
            r_velocity  <= '0;
            r_dir       <= 1'b1;
            r_en        <= 1'b1;
            r_period    <= '1;
            r_elapsed   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    ssrg_pkg::CFG_STEPS_PER_REV: begin
                        r_spr <= i_cfg_data[ssrg_pkg::SPR_W-1:0];
                    end
                    ssrg_pkg::CFG_GEAR_RATIO: begin
                        r_gear <= i_cfg_data[ssrg_pkg::GEAR_W-1:0];
                    end
                    ssrg_pkg::CFG_TICKS_PER_SECOND: begin
                        r_tps <= i_cfg_data[ssrg_pkg::TPS_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (is_tick) begin
                r_elapsed <= tick_step ? '0 : elapsed_inc;
            end
            if (is_vel) begin
                r_velocity <= vel_clamp;
                if (vel_clamp > 0) begin
                    r_dir <= 1'b1;
                end else if (vel_clamp < 0) begin
                    r_dir <= 1'b0;
                end
            end
            if (is_en) begin
                r_en <= i_enable_value;
            end
            if (i_cmd.finish) begin
                r_period <= period_new;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // divider and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_quo <= {num_prod, {ssrg_pkg::NUM_SHIFT{1'b0}}};
            r_rem <= '0;
            r_den <= den_prod;
            r_cnt <= CNT_W'(NUM_W - 1);
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[NUM_W-2:0], quo_bit};
            r_rem <= quo_bit ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
            r_cnt <= r_cnt - 1'b1;
        end
        if (out_load) begin
            // enable, direction, velocity: values after this beat's update
            r_out_data <= {
                is_vel ? vel_clamp : r_velocity,
                is_en ? i_enable_value : r_en,
                r_dir,
                is_tick && tick_step
            };
        end
    end

    assign o_sts.out_busy = r_out_valid && !i_m_tready;
    assign o_sts.div_last = i_cmd.div_step && (r_cnt == '0);

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = ssrg_pkg::M_TDATA_W'(r_out_data);

    a_finish_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> r_out_valid)
        else $error("velocity result not emitted");

    a_zero_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && r_den == '0) |=> (r_period == '1))
        else $error("zero divisor did not give infinite period");

    a_step_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_tick && tick_step) |=> (r_elapsed == '0 && r_out_data[0]))
        else $error("step did not clear elapsed count");

endmodule
